@@ rtl/core/srcs_pkg.sv @@
// Shared constants, opcodes and structs of the small RISC step core.
package srcs_pkg;

	localparam int MEM_BYTES = 256;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int LANES     = 4;
	localparam int LANE_W    = $clog2(LANES);
	localparam int ROWS      = MEM_BYTES / LANES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int REG_COUNT = 16;
	localparam int REG_W     = $clog2(REG_COUNT);
	localparam int WORD_W    = 32;
	localparam int PC_W      = 16;
	localparam int OP_W      = 8;

	localparam logic [PC_W-1:0] HALT_LIMIT = PC_W'(252);

	localparam logic [OP_W-1:0] OP_LDI = 8'h00;
	localparam logic [OP_W-1:0] OP_MOV = 8'h01;
	localparam logic [OP_W-1:0] OP_LDM = 8'h02;
	localparam logic [OP_W-1:0] OP_STM = 8'h03;
	localparam logic [OP_W-1:0] OP_CMP = 8'h04;
	localparam logic [OP_W-1:0] OP_JMP = 8'h05;
	localparam logic [OP_W-1:0] OP_JGT = 8'h06;
	localparam logic [OP_W-1:0] OP_JLT = 8'h07;
	localparam logic [OP_W-1:0] OP_JEQ = 8'h08;
	localparam logic [OP_W-1:0] OP_ADD = 8'h09;
	localparam logic [OP_W-1:0] OP_SUB = 8'h0A;
	localparam logic [OP_W-1:0] OP_AND = 8'h0B;
	localparam logic [OP_W-1:0] OP_OR  = 8'h0C;
	localparam logic [OP_W-1:0] OP_XOR = 8'h0D;
	localparam logic [OP_W-1:0] OP_SHL = 8'h0E;
	localparam logic [OP_W-1:0] OP_SRA = 8'h0F;

	typedef struct packed {
		logic              rd;
		logic              wr;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic g;
		logic l;
		logic e;
	} flags_t;

	typedef struct packed {
		logic [PC_W-1:0]   pc_after;
		logic              halted;
		logic              reg_written;
		logic [REG_W-1:0]  reg_index;
		logic [WORD_W-1:0] reg_value;
		logic              mem_written;
		flags_t            flags;
	} res_t;

endpackage

@@ rtl/core/srcs_umem.sv @@
// Unified byte memory: four byte lanes for unaligned, wrapping 32-bit access.
module srcs_umem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srcs_pkg::mem_req_t           req,
	output logic [srcs_pkg::WORD_W-1:0] rdata
);

	localparam int AW  = srcs_pkg::ADDR_W;
	localparam int LW  = srcs_pkg::LANE_W;
	localparam int RW  = srcs_pkg::ROW_W;
	localparam int NL  = srcs_pkg::LANES;
	localparam int NR  = srcs_pkg::ROWS;

	logic [LW-1:0]   off;
	logic [LW-1:0]   off_q;
	wire  [8*NL-1:0] lanes_flat;

	assign off = req.addr[LW-1:0];

	for (genvar l = 0; l < NL; l++) begin : g_lane
		logic [LW-1:0] k;
		logic [AW-1:0] baddr;
		logic [RW-1:0] row;
		logic [7:0]    mem [NR];
		logic [NR-1:0] vld_q;
		logic [7:0]    rd_q;
		logic          rd_vld_q;

		// byte k of the word lands in this lane
		assign k     = LW'(l) - off;
		assign baddr = req.addr + AW'(k);
		assign row   = baddr[AW-1:LW];

		always_ff @(posedge clk) begin
			if (req.wr) begin
				mem[row] <= req.wdata[8*k +: 8];
			end
			if (req.rd) begin
				rd_q <= mem[row];
			end
		end

		// unwritten bytes read as zero
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q    <= '0;
				rd_vld_q <= 1'b0;
			end else begin
				if (req.wr) begin
					vld_q[row] <= 1'b1;
				end
				if (req.rd) begin
					rd_vld_q <= vld_q[row];
				end
			end
		end

		assign lanes_flat[8*l +: 8] = rd_q & {8{rd_vld_q}};
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			off_q <= off;
		end
	end

	// rotate lanes back into word order
	always_comb begin
		rdata = '0;
		for (int k = 0; k < NL; k++) begin
			rdata[8*k +: 8] = lanes_flat[8*(LW'(off_q + LW'(k))) +: 8];
		end
	end

endmodule

@@ rtl/core/small_risc_core_step_core.sv @@
// A taken word is fetched, decoded in stage 1 and executed in stage 2; a data load returns in stage 3.
// No word is taken while the previous one decodes; a data load or store holds the next word longer,
// since fetch and data access share the single port of each memory byte lane.
// The pc of one step must be settled before the next fetch and its flags before the next decode.
// Reset clears pc, flags and pipeline control at once; memory bytes and registers carry
// valid bits and read as zero until written, so no clearing pass runs after reset.
module small_risc_core_step_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [5:0]         load_word_index,
	input  logic [31:0]        load_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        pc_after,
	output logic               halted,
	output logic               reg_written,
	output logic [3:0]         reg_index,
	output logic signed [31:0] reg_value,
	output logic               mem_written,
	output logic               flag_greater,
	output logic               flag_less,
	output logic               flag_equal
);

	localparam int AW        = srcs_pkg::ADDR_W;
	localparam int PW        = srcs_pkg::PC_W;
	localparam int WW        = srcs_pkg::WORD_W;
	localparam int RGW       = srcs_pkg::REG_W;
	localparam int RES_DEPTH = 2;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);

	// ---------------------------------------------------------------
	// Architectural state outside the memories
	// ---------------------------------------------------------------
	logic [PW-1:0]          pc_q;
	srcs_pkg::flags_t       flags_q;
	srcs_pkg::flags_t       flags_d;

	logic                   in_acc;
	logic                   acc_run;

	// stage 1: fetch data returns, decode, register file read, next pc
	logic                   valid_s1;
	logic                   step_s1;
	logic                   run_s1;
	logic [PW-1:0]          pc_s1;

	// stage 2: execute, compare, data access issue
	logic                   valid_s2;
	logic                   run_s2;
	logic [srcs_pkg::OP_W-1:0] op_s2;
	logic [RGW-1:0]         ra_s2;
	logic [15:0]            imm_s2;
	logic [3:0]             sh_s2;
	logic [PW-1:0]          pc_s2;
	logic [WW-1:0]          rf_a_s2;
	logic [WW-1:0]          rf_b_s2;
	logic                   rf_a_vld_s2;
	logic                   rf_b_vld_s2;

	// stage 3: data load returns
	logic                   valid_s3;
	logic [RGW-1:0]         ra_s3;
	logic [PW-1:0]          pc_s3;

	// register file
	logic [WW-1:0]                   rf_mem [srcs_pkg::REG_COUNT];
	logic [srcs_pkg::REG_COUNT-1:0] rf_vld_q;
	logic                            rf_we;
	logic [RGW-1:0]                  rf_waddr;
	logic [WW-1:0]                   rf_wdata;

	// memory port
	srcs_pkg::mem_req_t     mem_req;
	logic [WW-1:0]          mem_rdata;

	// decode
	logic [srcs_pkg::OP_W-1:0] d_op;
	logic [RGW-1:0]         d_ra;
	logic [RGW-1:0]         d_rb;
	logic [15:0]            d_imm;
	logic [3:0]             d_sh;
	logic                   d_take;
	logic [PW-1:0]          d_pc;

	// execute
	logic [WW-1:0]          e_a;
	logic [WW-1:0]          e_b;
	logic                   e_wr;
	logic [WW-1:0]          e_val;
	logic                   e_rf_we;
	logic                   e_cmp;
	logic                   e_ldm;
	logic                   e_stm;

	// result queue
	srcs_pkg::res_t         res_q [RES_DEPTH];
	srcs_pkg::res_t         res_d;
	srcs_pkg::res_t         res_head;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   push;
	logic                   pop;
	logic [1:0]             inflight;
	logic [2:0]             credit;

	// ---------------------------------------------------------------
	// Input handshake
	// Hold off a word while the previous one decodes (pc not settled),
	// while a data access owns the memory port, or when every result
	// slot is already taken or promised to a word in flight.
	// ---------------------------------------------------------------
	assign inflight = {1'b0, valid_s1} + {1'b0, valid_s2} + {1'b0, valid_s3};
	assign credit   = 3'(cnt_q) + {1'b0, inflight};
	assign in_stall = valid_s1 | (valid_s2 & (e_ldm | e_stm)) | (credit >= 3'(RES_DEPTH));
	assign in_acc   = in_valid & ~in_stall;
	assign acc_run  = req_type & (pc_q <= srcs_pkg::HALT_LIMIT);

	// ---------------------------------------------------------------
	// Unified memory: fetch or program load at accept, data access in stage 2
	// ---------------------------------------------------------------
	always_comb begin
		mem_req = '0;
		if (e_ldm) begin
			mem_req.rd   = 1'b1;
			mem_req.addr = e_b[AW-1:0];
		end else if (e_stm) begin
			mem_req.wr    = 1'b1;
			mem_req.addr  = e_a[AW-1:0];
			mem_req.wdata = e_b;
		end else if (in_acc && acc_run) begin
			mem_req.rd   = 1'b1;
			mem_req.addr = pc_q[AW-1:0];
		end else if (in_acc && !req_type) begin
			mem_req.wr    = 1'b1;
			mem_req.addr  = AW'({load_word_index, 2'b00});
			mem_req.wdata = load_word;
		end
	end

	srcs_umem u_umem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	// ---------------------------------------------------------------
	// Stage 1: decode the fetched word, resolve the next pc
	// Flags from any earlier compare are already in flags_q here.
	// ---------------------------------------------------------------
	assign d_op  = mem_rdata[7:0];
	assign d_rb  = mem_rdata[11:8];
	assign d_ra  = mem_rdata[15:12];
	assign d_imm = mem_rdata[31:16];
	assign d_sh  = mem_rdata[27:24];

	always_comb begin
		case (d_op)
			srcs_pkg::OP_JMP: d_take = 1'b1;
			srcs_pkg::OP_JGT: d_take = flags_q.g;
			srcs_pkg::OP_JLT: d_take = flags_q.l;
			srcs_pkg::OP_JEQ: d_take = flags_q.e;
			default:          d_take = 1'b0;
		endcase
		if (!step_s1) begin
			d_pc = '0;
		end else if (!run_s1) begin
			d_pc = pc_s1;
		end else begin
			d_pc = pc_s1 + PW'(4) + (d_take ? d_imm : PW'(0));
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: execute
	// ---------------------------------------------------------------
	assign e_a = rf_a_vld_s2 ? rf_a_s2 : '0;
	assign e_b = rf_b_vld_s2 ? rf_b_s2 : '0;

	always_comb begin
		e_wr  = 1'b1;
		e_val = '0;
		case (op_s2)
			srcs_pkg::OP_LDI: e_val = {{16{imm_s2[15]}}, imm_s2};
			srcs_pkg::OP_MOV: e_val = e_b;
			srcs_pkg::OP_ADD: e_val = e_a + e_b;
			srcs_pkg::OP_SUB: e_val = e_a - e_b;
			srcs_pkg::OP_AND: e_val = e_a & e_b;
			srcs_pkg::OP_OR:  e_val = e_a | e_b;
			srcs_pkg::OP_XOR: e_val = e_a ^ e_b;
			srcs_pkg::OP_SHL: e_val = e_a << sh_s2;
			srcs_pkg::OP_SRA: e_val = WW'($signed(e_a) >>> sh_s2);
			default:          e_wr  = 1'b0;
		endcase
	end

	assign e_rf_we = valid_s2 & run_s2 & e_wr;
	assign e_cmp   = valid_s2 & run_s2 & (op_s2 == srcs_pkg::OP_CMP);
	assign e_ldm   = valid_s2 & run_s2 & (op_s2 == srcs_pkg::OP_LDM);
	assign e_stm   = valid_s2 & run_s2 & (op_s2 == srcs_pkg::OP_STM);

	// signed compare; exactly one flag ends up set
	always_comb begin
		flags_d = flags_q;
		if (e_cmp) begin
			flags_d.e = (e_a == e_b);
			flags_d.g = ($signed(e_a) > $signed(e_b));
			flags_d.l = ($signed(e_a) < $signed(e_b));
		end
	end

	// ---------------------------------------------------------------
	// Register file write: execute results or returning load data.
	// The two never meet because a word after a data load enters late.
	// ---------------------------------------------------------------
	assign rf_we    = e_rf_we | valid_s3;
	assign rf_waddr = valid_s3 ? ra_s3 : ra_s2;
	assign rf_wdata = valid_s3 ? mem_rdata : e_val;

	// ---------------------------------------------------------------
	// Result assembly
	// ---------------------------------------------------------------
	always_comb begin
		res_d = '0;
		if (valid_s3) begin
			res_d.pc_after    = pc_s3;
			res_d.halted      = (pc_s3 > srcs_pkg::HALT_LIMIT);
			res_d.reg_written = 1'b1;
			res_d.reg_index   = ra_s3;
			res_d.reg_value   = mem_rdata;
			res_d.flags       = flags_q;
		end else begin
			res_d.pc_after    = pc_s2;
			res_d.halted      = (pc_s2 > srcs_pkg::HALT_LIMIT);
			res_d.reg_written = e_rf_we;
			res_d.reg_index   = e_rf_we ? ra_s2 : '0;
			res_d.reg_value   = e_rf_we ? e_val : '0;
			res_d.mem_written = e_stm;
			res_d.flags       = flags_d;
		end
	end

	// a data load reports from stage 3, everything else from stage 2
	assign push = (valid_s2 & ~e_ldm) | valid_s3;
	assign pop  = out_valid & ~out_stall;

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			pc_q        <= '0;
			flags_q     <= '0;
			rf_vld_q    <= '0;
			rf_a_vld_s2 <= 1'b0;
			rf_b_vld_s2 <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= e_ldm;
			flags_q  <= flags_d;
			if (valid_s1) begin
				pc_q        <= d_pc;
				rf_a_vld_s2 <= rf_vld_q[d_ra];
				rf_b_vld_s2 <= rf_vld_q[d_rb];
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// ---------------------------------------------------------------
	// Payload registers and register file array
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			step_s1 <= req_type;
			run_s1  <= acc_run;
			pc_s1   <= pc_q;
		end
		if (valid_s1) begin
			run_s2  <= run_s1;
			op_s2   <= d_op;
			ra_s2   <= d_ra;
			imm_s2  <= d_imm;
			sh_s2   <= d_sh;
			pc_s2   <= d_pc;
			rf_a_s2 <= rf_mem[d_ra];
			rf_b_s2 <= rf_mem[d_rb];
		end
		if (e_ldm) begin
			ra_s3 <= ra_s2;
			pc_s3 <= pc_s2;
		end
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		if (push) begin
			res_q[wr_ptr_q] <= res_d;
		end
	end

	// ---------------------------------------------------------------
	// Output word from the head of the result queue
	// ---------------------------------------------------------------
	assign res_head     = res_q[rd_ptr_q];
	assign out_valid    = (cnt_q != '0);
	assign pc_after     = res_head.pc_after;
	assign halted       = res_head.halted;
	assign reg_written  = res_head.reg_written;
	assign reg_index    = res_head.reg_index;
	assign reg_value    = res_head.reg_value;
	assign mem_written  = res_head.mem_written;
	assign flag_greater = res_head.flags.g;
	assign flag_less    = res_head.flags.l;
	assign flag_equal   = res_head.flags.e;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_port_single : assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd && mem_req.wr))
		else $error("memory lane port asked to read and write in one cycle");

	a_rf_single : assert property (@(posedge clk) disable iff (!arst_n)
		!(e_rf_we && valid_s3))
		else $error("execute and load return collide on register file write");

	a_credit : assert property (@(posedge clk) disable iff (!arst_n)
		credit <= 3'(RES_DEPTH))
		else $error("more results promised than result queue slots");

	a_spacing : assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_acc)
		else $error("word taken while previous one still decoding");

endmodule
